// File: sv/hrbp_pkg.sv
// ----------------------------------------------------------------------------
// hrbp_pkg
// Shared constants, types and the column formatting function of the
// history ring bar plot.
// ----------------------------------------------------------------------------
package hrbp_pkg;

	// Ring depth and derived widths
	localparam int DEPTH = 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	// Item kinds carried on the input tuser
	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_DRAW   = 1'b1;

	// Read issued to the sample memory, tracked down to the output buffer
	typedef struct packed {
		logic valid;
		logic last;
		logic page;
	} hrbp_issue_t;

	// Eight pixels of one column: 0xFF << (limit - height), byte-truncated
	function automatic logic [7:0] column_for(input logic [7:0] height, input logic page);
		logic [4:0] limit;
		logic [4:0] shift;
		logic [7:0] bits;
		limit = page ? 5'd8 : 5'd16;
		shift = limit - height[4:0];
		if (height >= {3'b000, limit}) begin
			bits = 8'hFF;
		end else if (shift >= 5'd8) begin
			bits = 8'h00;
		end else begin
			bits = 8'hFF << shift[2:0];
		end
		return bits;
	endfunction

endpackage

// File: sv/hrbp_ram.sv
// ----------------------------------------------------------------------------
// hrbp_ram
// Sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hrbp_ram
	import hrbp_pkg::*;
(
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// Store one sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read with registered output data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/hrbp_seq.sv
// ----------------------------------------------------------------------------
// hrbp_seq
// Ring pointers and draw sequencer: records samples, then walks the ring
// from oldest to newest issuing one memory read per credit.
// ----------------------------------------------------------------------------
module hrbp_seq
	import hrbp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_mode,
	input  logic [7:0]    in_sample,
	input  logic          in_page,
	input  logic          issue_ok,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic [AW-1:0] rd_addr,
	output hrbp_issue_t   issue
);

	typedef enum logic {
		ST_IDLE,
		ST_DRAW
	} state_t;

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	state_t        state_q;
	logic [AW-1:0] wr_pos_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_pos_q;
	logic [CW-1:0] remain_q;
	logic          page_q;

	logic          accept;
	logic          do_issue;
	logic [AW:0]   start_sum;
	logic [AW:0]   start_pos;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Write the sample of a record beat at the current slot
	assign wr_en   = accept && (in_mode == MODE_RECORD);
	assign wr_addr = wr_pos_q;
	assign wr_data = in_sample;

	// Oldest slot: write position minus count, modulo the depth
	assign start_sum = {1'b0, wr_pos_q} + (AW + 1)'(DEPTH) - (AW + 1)'(count_q);
	assign start_pos = (start_sum >= (AW + 1)'(DEPTH)) ? start_sum - (AW + 1)'(DEPTH)
	                                                   : start_sum;

	// Issue one read per cycle while the output side has room
	assign do_issue    = (state_q == ST_DRAW) && issue_ok;
	assign rd_addr     = rd_pos_q;
	assign issue.valid = do_issue;
	assign issue.last  = (remain_q == CW'(1));
	assign issue.page  = page_q;

	// Hold state, pointers and draw progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_pos_q <= '0;
			count_q  <= '0;
			rd_pos_q <= '0;
			remain_q <= '0;
			page_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_mode == MODE_RECORD) begin
							wr_pos_q <= (wr_pos_q == LAST_SLOT) ? '0 : wr_pos_q + AW'(1);
							if (count_q != FULL_CNT) begin
								count_q <= count_q + CW'(1);
							end
						end else if (count_q != '0) begin
							state_q  <= ST_DRAW;
							rd_pos_q <= start_pos[AW-1:0];
							remain_q <= count_q;
							page_q   <= in_page;
						end
					end
				end
				ST_DRAW: begin
					if (do_issue) begin
						rd_pos_q <= (rd_pos_q == LAST_SLOT) ? '0 : rd_pos_q + AW'(1);
						remain_q <= remain_q - CW'(1);
						if (remain_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored count above depth");

	a_draw_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (remain_q != '0) && (remain_q <= count_q))
		else $error("draw walking with bad remaining count");

	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(do_issue && issue.last) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after last column");

endmodule

// File: sv/hrbp_out.sv
// ----------------------------------------------------------------------------
// hrbp_out
// Column formatter and two-beat output buffer; grants read credits so
// that every issued read finds a free slot.
// ----------------------------------------------------------------------------
module hrbp_out
	import hrbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  hrbp_issue_t issue,
	input  logic [7:0]  rd_data,
	output logic        issue_ok,
	output logic        tvalid,
	input  logic        tready,
	output logic [7:0]  tdata,
	output logic        tlast
);

	hrbp_issue_t issue_s1;
	logic [7:0]  col_q  [2];
	logic        last_q [2];
	logic        wr_sel_q;
	logic        rd_sel_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic [1:0]  occ;

	assign push = issue_s1.valid;
	assign pop  = tvalid && tready;
	assign occ  = cnt_q + {1'b0, issue_s1.valid};

	// Grant a read when a slot is free after this cycle's pop
	assign issue_ok = (occ < 2'd2) || pop;

	assign tvalid = (cnt_q != 2'd0);
	assign tdata  = col_q[rd_sel_q];
	assign tlast  = last_q[rd_sel_q];

	// Track the read in flight alongside the memory latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
		end else begin
			issue_s1 <= issue;
		end
	end

	// Store formatted columns
	always_ff @(posedge clk) begin
		if (push) begin
			col_q[wr_sel_q]  <= column_for(rd_data, issue_s1.page);
			last_q[wr_sel_q] <= issue_s1.last;
		end
	end

	// Advance buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_sel_q <= 1'b0;
			rd_sel_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_sel_q <= ~wr_sel_q;
			end
			if (pop) begin
				rd_sel_q <= ~rd_sel_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (cnt_q == 2'd2) && !pop))
		else $error("column pushed into a full buffer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("buffer count out of range");

	a_drain_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tvalid) |-> $past(pop))
		else $error("output beat vanished without being taken");

endmodule

// File: sv/history_ring_bar_plot.sv
// A draw of N stored samples passes the sequencer state, the memory read
// register and the output buffer, then gives one column per cycle while the
// output accepts. A draw holds the input busy until its N reads are issued,
// one per column (single read port); otherwise records are taken every cycle.
// Reset: arst_n clears write position, stored count and buffers; sample
// memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// history_ring_bar_plot
// Ring of recent byte samples drawn as bar-graph columns, oldest first.
// ----------------------------------------------------------------------------
module history_ring_bar_plot
	import hrbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] sample, [8] page, [15:9] zero
	input  logic        s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] column_bits
	output logic        m_axis_tlast
);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          issue_ok;
	hrbp_issue_t   issue;

	// Sequence records and draws
	hrbp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_sample (s_axis_tdata[7:0]),
		.in_page   (s_axis_tdata[8]),
		.issue_ok  (issue_ok),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.issue     (issue)
	);

	// Hold the samples
	hrbp_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue.valid),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Format and buffer columns
	hrbp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.rd_data  (rd_data),
		.issue_ok (issue_ok),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tlast    (m_axis_tlast)
	);

endmodule

// File: bench/ring_plot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_plot_checker
// Watches both stream channels of the history ring bar plot. It keeps its own
// ring of recorded samples, works out the columns each draw beat must give,
// and compares every output beat, in order, with the oldest column expected.
// ----------------------------------------------------------------------------
module ring_plot_checker
	import hrbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] sample, [8] page, [15:9] zero
	input  logic        s_axis_tuser,  // [0] mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // [7:0] column_bits
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          columns_pending
);

	typedef struct packed {
		logic [7:0] bits;
		logic       last;
	} plot_column_t;

	// Shadow copy of the ring
	logic [7:0]   history [DEPTH];
	int           next_slot;
	int           fill_level;
	plot_column_t columns_due [$];

	plot_column_t want;
	int           n_cols;
	int           slot;
	logic [7:0]   in_sample;
	logic         in_page;

	initial begin
		mismatches      = 0;
		columns_pending = 0;
	end

	// Bar column for one stored height: full at or above the page limit, empty far below
	function automatic logic [7:0] bar_column(input logic [7:0] height, input logic pg);
		int ceiling;
		int gap;
		ceiling = pg ? 8 : 16;
		if (height >= ceiling)
			return 8'hFF;
		gap = ceiling - height;
		if (gap >= 8)
			return 8'h00;
		return 8'hFF << gap;
	endfunction

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot  = 0;
			fill_level = 0;
			columns_due.delete();
			columns_pending <= 0;
		end else begin
			// Predict on every accepted input beat
			if (s_axis_tvalid && s_axis_tready) begin
				in_sample = s_axis_tdata[7:0];
				in_page   = s_axis_tdata[8];
				if (s_axis_tuser == MODE_RECORD) begin
					history[next_slot] = in_sample;
					next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
					if (fill_level < DEPTH)
						fill_level++;
				end else begin
					n_cols = fill_level;
					slot   = (next_slot + DEPTH - n_cols) % DEPTH;
					for (int i = 0; i < n_cols; i++) begin
						want.bits = bar_column(history[slot], in_page);
						want.last = (i == n_cols - 1);
						columns_due.push_back(want);
						slot = (slot + 1) % DEPTH;
					end
				end
			end

			// Compare each accepted output beat with the oldest column due
			if (m_axis_tvalid && m_axis_tready) begin
				if (columns_due.size() == 0) begin
					report_mismatch($sformatf("unexpected column %02h last %b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = columns_due.pop_front();
					if (m_axis_tdata !== want.bits)
						report_mismatch($sformatf("column_bits %02h, expected %02h",
							m_axis_tdata, want.bits));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last_column %b, expected %b",
							m_axis_tlast, want.last));
				end
			end

			columns_pending <= columns_due.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the history ring bar plot. Records and draws are
// sent with random gaps while the output side stalls at random; a separate
// checker predicts every column and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	import hrbp_pkg::*;

	localparam int  CYCLE_LIMIT  = 1_000_000;
	localparam int  TAIL_CYCLES  = 2 * DEPTH + 16;
	localparam int  RANDOM_ITEMS = 180;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] sample, [8] page, [15:9] zero
	logic        s_axis_tuser = MODE_RECORD;  // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // [7:0] column_bits
	logic        m_axis_tlast;

	int   mismatches;
	int   columns_pending;
	int   cycles = 0;
	logic steady = 1'b0;
	int   ready_hold = 0;

	history_ring_bar_plot dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	ring_plot_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.mismatches      (mismatches),
		.columns_pending (columns_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Stall the output side at random, never in a steady stretch
	always @(posedge clk) begin
		if (steady) begin
			m_axis_tready <= 1'b1;
			ready_hold    <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < 70);
			ready_hold    <= idle_length();
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Send one beat and hold it until accepted, then idle for a random gap (none when steady)
	task automatic send_beat(input logic mode, input logic [7:0] sample, input logic page);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, page, sample};
		s_axis_tuser  <= mode;
		do @(posedge clk); while (!s_axis_tready);
		gap = steady ? 0 : idle_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the input until every predicted column has come out
	task automatic drain_columns();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (columns_pending != 0) @(posedge clk);
	endtask

	logic       r_mode;
	logic [7:0] r_sample;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Draw both pages on an empty ring: no columns
		send_beat(MODE_DRAW, 8'h00, 1'b0);
		send_beat(MODE_DRAW, 8'hFF, 1'b1);
		// Single stored sample, page bit ignored on a record
		send_beat(MODE_RECORD, 8'h00, 1'b1);
		send_beat(MODE_DRAW, 8'hFF, 1'b0);
		// Heights around both page limits and the byte extremes
		send_beat(MODE_RECORD, 8'd1, 1'b0);
		send_beat(MODE_RECORD, 8'd7, 1'b1);
		send_beat(MODE_RECORD, 8'd8, 1'b0);
		send_beat(MODE_RECORD, 8'd9, 1'b1);
		send_beat(MODE_RECORD, 8'd15, 1'b0);
		send_beat(MODE_RECORD, 8'd16, 1'b1);
		send_beat(MODE_RECORD, 8'd17, 1'b0);
		send_beat(MODE_RECORD, 8'd128, 1'b0);
		send_beat(MODE_RECORD, 8'd255, 1'b1);
		send_beat(MODE_DRAW, 8'h5A, 1'b0);
		send_beat(MODE_DRAW, 8'hA5, 1'b1);
		drain_columns();

		// Random records and draws; every third phase runs without idling
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 30 == 0)
				steady <= ((i / 30) % 3 == 2);
			r_mode   = ($urandom_range(0, 99) < 20) ? MODE_DRAW : MODE_RECORD;
			r_sample = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20))
			                                       : 8'($urandom_range(0, 255));
			send_beat(r_mode, r_sample, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 11) == 0)
				drain_columns();
		end
		steady <= 1'b0;
		send_beat(MODE_DRAW, 8'h00, 1'b0);
		send_beat(MODE_DRAW, 8'h00, 1'b1);

		// Wait out the last columns, then a quiet tail
		drain_columns();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && columns_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
